/* hw/rtl/aff2d_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// aff2d_pkg
// Shared types, codes and constants of the 2D affine vertex transform.
// ----------------------------------------------------------------------------
package aff2d_pkg;

    // Coordinate and register formats
    localparam int COORD_W    = 32;
    localparam int MODE_W     = 4;
    localparam int ANGLE_W    = 16;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 32;

    localparam logic signed [COORD_W-1:0] COORD_MAX = 32'sh7FFF_FFFF;
    localparam logic signed [COORD_W-1:0] COORD_MIN = 32'sh8000_0000;

    // Cosine and sine: signed Q2.16
    localparam int TRIG_W    = 18;
    localparam int TRIG_FRAC = 16;
    localparam int TRIG_ONE  = 65536;

    // Datapath operand widths
    localparam int OPA_W  = COORD_W + 1;
    localparam int OPB_W  = COORD_W;
    localparam int BASE_W = COORD_W + 1;
    localparam int PROD_W = OPA_W + OPB_W;
    localparam int SUM_W  = PROD_W + 1;

    // CORDIC constants; angles in 1/64 degree
    localparam int DEG360           = 23040;
    localparam int DEG180           = 11520;
    localparam int DEG90            = 5760;
    localparam int CORDIC_X_W       = 34;
    localparam int CORDIC_Z_W       = 25;
    localparam int CORDIC_GAIN      = 652032874;
    localparam int CORDIC_ZSCALE_SH = 10;
    localparam int CORDIC_OUT_SH    = 14;
    localparam int ATAN_IDX_W       = 5;

    typedef enum logic [MODE_W-1:0] {
        MODE_SCALE     = 4'd0,
        MODE_TRANSLATE = 4'd1,
        MODE_ROTATE    = 4'd2,
        MODE_REFL_X    = 4'd3,
        MODE_REFL_Y    = 4'd4,
        MODE_REFL_ORG  = 4'd5,
        MODE_REFL_DIAG = 4'd6,
        MODE_REFL_ANTI = 4'd7,
        MODE_XSHEAR    = 4'd8,
        MODE_YSHEAR    = 4'd9
    } t_mode;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_MODE    = 3'd0,
        CFG_PARAM_X = 3'd1,
        CFG_PARAM_Y = 3'd2,
        CFG_ANGLE   = 3'd3
    } t_cfg_idx;

    typedef enum logic [1:0] {
        TRIG_IDLE,
        TRIG_RUN,
        TRIG_DONE
    } t_trig_state;

    // Per-coordinate operands: result = base + round(a1*b1 + a2*b2)
    typedef struct packed {
        logic signed [OPA_W-1:0]  a1;
        logic signed [OPB_W-1:0]  b1;
        logic signed [OPA_W-1:0]  a2;
        logic signed [OPB_W-1:0]  b2;
        logic signed [BASE_W-1:0] base;
        logic                     rot;
    } t_lane_op;

    // Load enables of the lane stages
    typedef struct packed {
        logic s2;
        logic s3;
        logic s4;
    } t_stage_en;

    // atan(2^-i) in units of 2^-16 degree
    function automatic logic [CORDIC_Z_W-1:0] atan_entry(input logic [ATAN_IDX_W-1:0] idx);
        logic [CORDIC_Z_W-1:0] v;
        case (idx)
            5'd0:    v = 25'd2949120;
            5'd1:    v = 25'd1740967;
            5'd2:    v = 25'd919879;
            5'd3:    v = 25'd466945;
            5'd4:    v = 25'd234379;
            5'd5:    v = 25'd117304;
            5'd6:    v = 25'd58666;
            5'd7:    v = 25'd29335;
            5'd8:    v = 25'd14668;
            5'd9:    v = 25'd7334;
            5'd10:   v = 25'd3667;
            5'd11:   v = 25'd1833;
            5'd12:   v = 25'd917;
            5'd13:   v = 25'd458;
            5'd14:   v = 25'd229;
            5'd15:   v = 25'd115;
            5'd16:   v = 25'd57;
            5'd17:   v = 25'd29;
            5'd18:   v = 25'd14;
            5'd19:   v = 25'd7;
            5'd20:   v = 25'd4;
            5'd21:   v = 25'd2;
            5'd22:   v = 25'd1;
            default: v = 25'd0;
        endcase
        return v;
    endfunction

endpackage
`default_nettype wire

/* hw/rtl/aff2d_in_if.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// aff2d_in_if
// Vertex input channel: valid/ready with one (x, y) beat.
// ----------------------------------------------------------------------------
interface aff2d_in_if;
    logic                                   valid;
    logic                                   ready;
    logic signed [aff2d_pkg::COORD_W-1:0]   x_in;
    logic signed [aff2d_pkg::COORD_W-1:0]   y_in;

    modport source (output valid, output x_in, output y_in, input ready);
    modport sink   (input valid, input x_in, input y_in, output ready);
endinterface
`default_nettype wire

/* hw/rtl/aff2d_out_if.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// aff2d_out_if
// Vertex result channel: valid/ready with one transformed vertex beat.
// ----------------------------------------------------------------------------
interface aff2d_out_if;
    logic                                   valid;
    logic                                   ready;
    logic signed [aff2d_pkg::COORD_W-1:0]   x_out;
    logic signed [aff2d_pkg::COORD_W-1:0]   y_out;
    logic                                   saturated;

    modport source (output valid, output x_out, output y_out, output saturated, input ready);
    modport sink   (input valid, input x_out, input y_out, input saturated, output ready);
endinterface
`default_nettype wire

/* hw/rtl/aff2d_trig.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// aff2d_trig
// Iterative CORDIC: cosine and sine of the rotation angle, one step a cycle.
// ----------------------------------------------------------------------------
module aff2d_trig #(
    parameter int CORDIC_STEPS = 16
) (
    input  logic                                   i_clk,
    input  logic                                   i_rst_n,
    input  logic                                   i_load,
    input  logic signed [aff2d_pkg::ANGLE_W-1:0]   i_angle,
    output logic signed [aff2d_pkg::TRIG_W-1:0]    o_cos,
    output logic signed [aff2d_pkg::TRIG_W-1:0]    o_sin,
    output logic                                   o_busy
);
    localparam int STEP_W = (CORDIC_STEPS > 1) ? $clog2(CORDIC_STEPS) : 1;
    localparam int AW     = aff2d_pkg::ANGLE_W + 1;
    localparam int XW     = aff2d_pkg::CORDIC_X_W;
    localparam int ZW     = aff2d_pkg::CORDIC_Z_W;
    localparam int TW     = aff2d_pkg::TRIG_W;

    localparam logic [STEP_W-1:0]    LAST_STEP = STEP_W'(CORDIC_STEPS - 1);
    localparam logic signed [AW-1:0] A360      = AW'(aff2d_pkg::DEG360);
    localparam logic signed [AW-1:0] A180      = AW'(aff2d_pkg::DEG180);
    localparam logic signed [AW-1:0] A90       = AW'(aff2d_pkg::DEG90);
    localparam logic signed [XW-1:0] X_INIT    = XW'(aff2d_pkg::CORDIC_GAIN);
    localparam logic signed [XW-1:0] RND       = XW'(1) <<< (aff2d_pkg::CORDIC_OUT_SH - 1);
    localparam logic signed [XW-1:0] T_HI      = XW'(aff2d_pkg::TRIG_ONE);
    localparam logic signed [XW-1:0] T_LO      = -T_HI;
    localparam logic signed [TW-1:0] T_ONE     = TW'(aff2d_pkg::TRIG_ONE);

    aff2d_pkg::t_trig_state r_state, n_state;

    logic signed [XW-1:0] r_x, n_x, r_y, n_y;
    logic signed [ZW-1:0] r_z, n_z;
    logic [STEP_W-1:0]    r_i, n_i;
    logic                 r_neg, n_neg, r_zero, n_zero;
    logic signed [TW-1:0] r_cos, n_cos, r_sin, n_sin;

    logic signed [AW-1:0] a_in, a_wrap, a_fold;
    logic                 fold_neg;
    logic signed [XW-1:0] step_dx, step_dy, x_rnd, y_rnd;
    logic signed [ZW-1:0] step_atan;
    logic signed [TW-1:0] x_clip, y_clip;

    function automatic logic signed [TW-1:0] clip_trig(input logic signed [XW-1:0] v);
        logic signed [XW-1:0] c;
        c = v;
        if (v > T_HI) begin
            c = T_HI;
        end else if (v < T_LO) begin
            c = T_LO;
        end
        return TW'(c);
    endfunction

    // Reduce the written angle into [-90, 90] degrees, remember a half-turn fold
    always_comb begin
        a_in     = AW'(i_angle);
        a_wrap   = a_in;
        a_fold   = a_in;
        fold_neg = 1'b0;
        if (a_in > A180) begin
            a_wrap = a_in - A360;
        end else if (a_in < -A180) begin
            a_wrap = a_in + A360;
        end
        a_fold = a_wrap;
        if (a_wrap > A90) begin
            a_fold   = a_wrap - A180;
            fold_neg = 1'b1;
        end else if (a_wrap < -A90) begin
            a_fold   = a_wrap + A180;
            fold_neg = 1'b1;
        end
    end

    assign step_dx   = r_y >>> r_i;
    assign step_dy   = r_x >>> r_i;
    assign step_atan = $signed(aff2d_pkg::atan_entry(aff2d_pkg::ATAN_IDX_W'(r_i)));
    assign x_rnd     = (r_x + RND) >>> aff2d_pkg::CORDIC_OUT_SH;
    assign y_rnd     = (r_y + RND) >>> aff2d_pkg::CORDIC_OUT_SH;
    assign x_clip    = clip_trig(x_rnd);
    assign y_clip    = clip_trig(y_rnd);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= aff2d_pkg::TRIG_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        n_x     = r_x;
        n_y     = r_y;
        n_z     = r_z;
        n_i     = r_i;
        n_neg   = r_neg;
        n_zero  = r_zero;
        n_cos   = r_cos;
        n_sin   = r_sin;
        case (r_state)
            aff2d_pkg::TRIG_IDLE: begin
            end
            aff2d_pkg::TRIG_RUN: begin
                if (r_z >= 0) begin
                    n_x = r_x - step_dx;
                    n_y = r_y + step_dy;
                    n_z = r_z - step_atan;
                end else begin
                    n_x = r_x + step_dx;
                    n_y = r_y - step_dy;
                    n_z = r_z + step_atan;
                end
                if (r_i == LAST_STEP) begin
                    n_state = aff2d_pkg::TRIG_DONE;
                end else begin
                    n_i = r_i + 1'b1;
                end
            end
            aff2d_pkg::TRIG_DONE: begin
                // A folded zero angle is an exact half-turn or no turn
                if (r_zero) begin
                    n_cos = r_neg ? -T_ONE : T_ONE;
                    n_sin = '0;
                end else begin
                    n_cos = r_neg ? -x_clip : x_clip;
                    n_sin = r_neg ? -y_clip : y_clip;
                end
                n_state = aff2d_pkg::TRIG_IDLE;
            end
            default: begin
                n_state = aff2d_pkg::TRIG_IDLE;
            end
        endcase
        if (i_load) begin
            n_state = aff2d_pkg::TRIG_RUN;
            n_x     = X_INIT;
            n_y     = '0;
            n_z     = ZW'(a_fold) <<< aff2d_pkg::CORDIC_ZSCALE_SH;
            n_i     = '0;
            n_neg   = fold_neg;
            n_zero  = (a_fold == '0);
        end
    end

    always_ff @(posedge i_clk) begin
        r_x    <= n_x;
        r_y    <= n_y;
        r_z    <= n_z;
        r_i    <= n_i;
        r_neg  <= n_neg;
        r_zero <= n_zero;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cos <= T_ONE;
            r_sin <= '0;
        end else begin
            r_cos <= n_cos;
            r_sin <= n_sin;
        end
    end

    assign o_cos  = r_cos;
    assign o_sin  = r_sin;
    assign o_busy = (r_state != aff2d_pkg::TRIG_IDLE);

endmodule
`default_nettype wire

/* hw/rtl/aff2d_oper.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// aff2d_oper
// First stage: form multiplier operands and base term of both lanes by mode.
// ----------------------------------------------------------------------------
module aff2d_oper (
    input  logic                                   i_clk,
    input  logic                                   i_en,
    input  logic signed [aff2d_pkg::COORD_W-1:0]   i_x,
    input  logic signed [aff2d_pkg::COORD_W-1:0]   i_y,
    input  logic [aff2d_pkg::MODE_W-1:0]           i_mode,
    input  logic signed [aff2d_pkg::COORD_W-1:0]   i_px,
    input  logic signed [aff2d_pkg::COORD_W-1:0]   i_py,
    input  logic signed [aff2d_pkg::TRIG_W-1:0]    i_cos,
    input  logic signed [aff2d_pkg::TRIG_W-1:0]    i_sin,
    output aff2d_pkg::t_lane_op                    o_op_x,
    output aff2d_pkg::t_lane_op                    o_op_y
);
    localparam int BW = aff2d_pkg::BASE_W;
    localparam int OB = aff2d_pkg::OPB_W;

    logic signed [BW-1:0] xe, ye, pxe, pye, dx, dy;
    logic signed [OB-1:0] cosb, sinb;
    aff2d_pkg::t_lane_op  n_op_x, n_op_y, r_op_x, r_op_y;

    assign xe   = BW'(i_x);
    assign ye   = BW'(i_y);
    assign pxe  = BW'(i_px);
    assign pye  = BW'(i_py);
    assign dx   = xe - pxe;
    assign dy   = ye - pye;
    assign cosb = OB'(i_cos);
    assign sinb = OB'(i_sin);

    always_comb begin
        n_op_x.a1   = '0;
        n_op_x.b1   = '0;
        n_op_x.a2   = '0;
        n_op_x.b2   = '0;
        n_op_x.base = xe;
        n_op_x.rot  = 1'b0;
        n_op_y.a1   = '0;
        n_op_y.b1   = '0;
        n_op_y.a2   = '0;
        n_op_y.b2   = '0;
        n_op_y.base = ye;
        n_op_y.rot  = 1'b0;
        case (aff2d_pkg::t_mode'(i_mode))
            aff2d_pkg::MODE_SCALE: begin
                n_op_x.a1   = xe;
                n_op_x.b1   = i_px;
                n_op_x.base = '0;
                n_op_y.a1   = ye;
                n_op_y.b1   = i_py;
                n_op_y.base = '0;
            end
            aff2d_pkg::MODE_TRANSLATE: begin
                n_op_x.base = xe + pxe;
                n_op_y.base = ye + pye;
            end
            aff2d_pkg::MODE_ROTATE: begin
                n_op_x.a1   = dx;
                n_op_x.b1   = cosb;
                n_op_x.a2   = dy;
                n_op_x.b2   = -sinb;
                n_op_x.base = pxe;
                n_op_x.rot  = 1'b1;
                n_op_y.a1   = dx;
                n_op_y.b1   = sinb;
                n_op_y.a2   = dy;
                n_op_y.b2   = cosb;
                n_op_y.base = pye;
                n_op_y.rot  = 1'b1;
            end
            aff2d_pkg::MODE_REFL_X: begin
                n_op_y.base = -ye;
            end
            aff2d_pkg::MODE_REFL_Y: begin
                n_op_x.base = -xe;
            end
            aff2d_pkg::MODE_REFL_ORG: begin
                n_op_x.base = -xe;
                n_op_y.base = -ye;
            end
            aff2d_pkg::MODE_REFL_DIAG: begin
                n_op_x.base = ye;
                n_op_y.base = xe;
            end
            aff2d_pkg::MODE_REFL_ANTI: begin
                n_op_x.base = -ye;
                n_op_y.base = -xe;
            end
            aff2d_pkg::MODE_XSHEAR: begin
                n_op_x.a1 = ye;
                n_op_x.b1 = i_px;
            end
            aff2d_pkg::MODE_YSHEAR: begin
                n_op_y.a1 = xe;
                n_op_y.b1 = i_py;
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_op_x <= n_op_x;
            r_op_y <= n_op_y;
        end
    end

    assign o_op_x = r_op_x;
    assign o_op_y = r_op_y;

endmodule
`default_nettype wire

/* hw/rtl/aff2d_lane.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// aff2d_lane
// One coordinate: multiply, sum and round, add base and saturate.
// ----------------------------------------------------------------------------
module aff2d_lane #(
    parameter int COORD_FRAC_BITS = 16
) (
    input  logic                                   i_clk,
    input  aff2d_pkg::t_stage_en                   i_en,
    input  aff2d_pkg::t_lane_op                    i_op,
    output logic signed [aff2d_pkg::COORD_W-1:0]   o_val,
    output logic                                   o_sat
);
    localparam int PW     = aff2d_pkg::PROD_W;
    localparam int SW     = aff2d_pkg::SUM_W;
    localparam int BW     = aff2d_pkg::BASE_W;
    localparam int CW     = aff2d_pkg::COORD_W;
    localparam int TF     = aff2d_pkg::TRIG_FRAC;
    localparam int MIN_SH = (COORD_FRAC_BITS < TF) ? COORD_FRAC_BITS : TF;
    localparam int RW     = SW - MIN_SH + 1;

    localparam logic signed [SW-1:0] HALF_C = SW'(1) <<< (COORD_FRAC_BITS - 1);
    localparam logic signed [SW-1:0] HALF_T = SW'(1) <<< (TF - 1);

    logic signed [PW-1:0] r_p1, r_p2;
    logic signed [BW-1:0] r_base2, r_base3;
    logic                 r_rot2, r_rot3;
    logic signed [SW-1:0] r_sum, shifted;
    logic signed [RW-1:0] total;
    logic [RW-CW:0]       upper;
    logic signed [CW-1:0] n_val, r_val;
    logic                 n_sat, r_sat;

    // Stage 2: products
    always_ff @(posedge i_clk) begin
        if (i_en.s2) begin
            r_p1    <= PW'(i_op.a1) * PW'(i_op.b1);
            r_p2    <= PW'(i_op.a2) * PW'(i_op.b2);
            r_base2 <= i_op.base;
            r_rot2  <= i_op.rot;
        end
    end

    // Stage 3: sum and add half an LSB of the chosen format
    always_ff @(posedge i_clk) begin
        if (i_en.s3) begin
            r_sum   <= SW'(r_p1) + SW'(r_p2) + (r_rot2 ? HALF_T : HALF_C);
            r_base3 <= r_base2;
            r_rot3  <= r_rot2;
        end
    end

    // Stage 4: drop fraction, add base, clip to 32 bits
    always_comb begin
        shifted = r_rot3 ? (r_sum >>> TF) : (r_sum >>> COORD_FRAC_BITS);
        total   = RW'(shifted) + RW'(r_base3);
        upper   = total[RW-1:CW-1];
        n_val   = total[CW-1:0];
        n_sat   = 1'b0;
        if (!((&upper) || !(|upper))) begin
            n_sat = 1'b1;
            n_val = total[RW-1] ? aff2d_pkg::COORD_MIN : aff2d_pkg::COORD_MAX;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en.s4) begin
            r_val <= n_val;
            r_sat <= n_sat;
        end
    end

    assign o_val = r_val;
    assign o_sat = r_sat;

endmodule
`default_nettype wire

/* hw/rtl/affine_2d_vertex_transform_unit.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// affine_2d_vertex_transform_unit
// 2D homogeneous affine transform of a vertex stream, [x y 1] * T.
// ----------------------------------------------------------------------------
// Usage:
//   i_vtx carries one vertex (x_in, y_in, signed Q16.16) per beat; o_res
//   returns one transformed vertex (x_out, y_out, saturated) per beat, in
//   order. Both are valid/ready channels; a beat moves when both are high.
//   Mode, param_x, param_y and angle_deg are written through i_cfg_we /
//   i_cfg_idx / i_cfg_wdata while no vertex is in flight.
//   An accepted input beat passes the four-stage operand / multiply /
//   round / saturate pipeline; throughput is one vertex per cycle while
//   o_res.ready is high and the CORDIC is idle. Each stage holds its own
//   valid bit, so bubbles close up and input beats are still taken while
//   a finished result waits in the output register.
//   An angle write starts the CORDIC, which runs its iterations and then a
//   done state; i_vtx.ready stays low while it runs.
//   Reset (synchronous, active low) empties the pipeline and restores
//   mode 0 (scale), param_x = param_y = 1.0, cosine 1.0 and sine 0.
//   When the receiver stalls, the result holds on o_res and the stages
//   behind it fill up before i_vtx.ready drops.
// ----------------------------------------------------------------------------
module affine_2d_vertex_transform_unit #(
    parameter int COORD_FRAC_BITS = 16,
    parameter int CORDIC_STEPS    = 16
) (
    input  logic                                   i_clk,
    input  logic                                   i_rst_n,
    aff2d_in_if.sink                               i_vtx,
    aff2d_out_if.source                            o_res,
    input  logic                                   i_cfg_we,
    input  logic [aff2d_pkg::CFG_IDX_W-1:0]        i_cfg_idx,
    input  logic [aff2d_pkg::CFG_DATA_W-1:0]       i_cfg_wdata
);
    localparam int CW = aff2d_pkg::COORD_W;
    localparam int TW = aff2d_pkg::TRIG_W;
    localparam logic signed [CW-1:0] ONE_Q = CW'(1) <<< COORD_FRAC_BITS;

    // Configuration registers
    logic [aff2d_pkg::MODE_W-1:0] r_mode;
    logic signed [CW-1:0]         r_px, r_py;
    logic                         angle_load;

    // Pipeline valid bits and stage readiness
    logic r_v1, r_v2, r_v3, r_v4;
    logic rdy1, rdy2, rdy3, rdy4;
    logic in_acc;

    logic signed [TW-1:0] cos_q, sin_q;
    logic                 trig_busy;

    aff2d_pkg::t_lane_op  op_x, op_y;
    aff2d_pkg::t_stage_en lane_en;
    logic signed [CW-1:0] val_x, val_y;
    logic                 sat_x, sat_y;

    assign angle_load = i_cfg_we &&
                        (aff2d_pkg::t_cfg_idx'(i_cfg_idx) == aff2d_pkg::CFG_ANGLE);

    // Register writes; indexes beyond the list fall through and are dropped
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode <= aff2d_pkg::MODE_SCALE;
            r_px   <= ONE_Q;
            r_py   <= ONE_Q;
        end else if (i_cfg_we) begin
            case (aff2d_pkg::t_cfg_idx'(i_cfg_idx))
                aff2d_pkg::CFG_MODE:    r_mode <= i_cfg_wdata[aff2d_pkg::MODE_W-1:0];
                aff2d_pkg::CFG_PARAM_X: r_px   <= i_cfg_wdata[CW-1:0];
                aff2d_pkg::CFG_PARAM_Y: r_py   <= i_cfg_wdata[CW-1:0];
                default: begin
                end
            endcase
        end
    end

    // Cosine and sine, recomputed on every angle write
    aff2d_trig #(
        .CORDIC_STEPS (CORDIC_STEPS)
    ) u_trig (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_load  (angle_load),
        .i_angle (i_cfg_wdata[aff2d_pkg::ANGLE_W-1:0]),
        .o_cos   (cos_q),
        .o_sin   (sin_q),
        .o_busy  (trig_busy)
    );

    // A stage may load when it is empty or the stage after it advances
    assign rdy4        = !r_v4 || o_res.ready;
    assign rdy3        = !r_v3 || rdy4;
    assign rdy2        = !r_v2 || rdy3;
    assign rdy1        = !r_v1 || rdy2;
    assign i_vtx.ready = rdy1 && !trig_busy;
    assign in_acc      = i_vtx.valid && i_vtx.ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
            r_v4 <= 1'b0;
        end else begin
            if (rdy1) begin
                r_v1 <= in_acc;
            end
            if (rdy2) begin
                r_v2 <= r_v1;
            end
            if (rdy3) begin
                r_v3 <= r_v2;
            end
            if (rdy4) begin
                r_v4 <= r_v3;
            end
        end
    end

    assign lane_en.s2 = rdy2;
    assign lane_en.s3 = rdy3;
    assign lane_en.s4 = rdy4;

    // Stage 1: operand selection for both lanes
    aff2d_oper u_oper (
        .i_clk  (i_clk),
        .i_en   (rdy1),
        .i_x    (i_vtx.x_in),
        .i_y    (i_vtx.y_in),
        .i_mode (r_mode),
        .i_px   (r_px),
        .i_py   (r_py),
        .i_cos  (cos_q),
        .i_sin  (sin_q),
        .o_op_x (op_x),
        .o_op_y (op_y)
    );

    // Stages 2 to 4, one lane per coordinate
    aff2d_lane #(
        .COORD_FRAC_BITS (COORD_FRAC_BITS)
    ) u_lane_x (
        .i_clk (i_clk),
        .i_en  (lane_en),
        .i_op  (op_x),
        .o_val (val_x),
        .o_sat (sat_x)
    );

    aff2d_lane #(
        .COORD_FRAC_BITS (COORD_FRAC_BITS)
    ) u_lane_y (
        .i_clk (i_clk),
        .i_en  (lane_en),
        .i_op  (op_y),
        .o_val (val_y),
        .o_sat (sat_y)
    );

    assign o_res.valid     = r_v4;
    assign o_res.x_out     = val_x;
    assign o_res.y_out     = val_y;
    assign o_res.saturated = sat_x || sat_y;

endmodule
`default_nettype wire

/* hw/rtl/aff2d_checker.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// aff2d_checker
// Port-level checks of the vertex transform, bound to the top level.
// ----------------------------------------------------------------------------
module aff2d_checker (
    input logic                                   i_clk,
    input logic                                   i_rst_n,
    input logic                                   i_in_valid,
    input logic                                   i_in_ready,
    input logic                                   i_out_valid,
    input logic                                   i_out_ready,
    input logic signed [aff2d_pkg::COORD_W-1:0]   i_x_out,
    input logic signed [aff2d_pkg::COORD_W-1:0]   i_y_out,
    input logic                                   i_saturated
);
    logic in_acc;

    assign in_acc = i_in_valid && i_in_ready;

    // Reset empties the pipeline
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !i_out_valid)
        else $error("result valid right after reset");

    // A stalled result holds
    a_stall_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=>
            i_out_valid && $stable(i_x_out) && $stable(i_y_out) && $stable(i_saturated))
        else $error("stalled result changed");

    // With the receiver ready, an accepted vertex passes every stage and comes out
    a_latency: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_acc ##1 i_out_ready ##1 i_out_ready ##1 i_out_ready |=> i_out_valid)
        else $error("result missing after pipeline latency");

    // The flag means at least one coordinate sits at a range limit
    a_sat_limit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && i_saturated |->
            (i_x_out == aff2d_pkg::COORD_MAX) || (i_x_out == aff2d_pkg::COORD_MIN) ||
            (i_y_out == aff2d_pkg::COORD_MAX) || (i_y_out == aff2d_pkg::COORD_MIN))
        else $error("saturated flag without a clipped coordinate");

endmodule

bind affine_2d_vertex_transform_unit aff2d_checker u_aff2d_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_vtx.valid),
    .i_in_ready  (i_vtx.ready),
    .i_out_valid (o_res.valid),
    .i_out_ready (o_res.ready),
    .i_x_out     (o_res.x_out),
    .i_y_out     (o_res.y_out),
    .i_saturated (o_res.saturated)
);
`default_nettype wire
